[rtl/ctu_pkg.sv]
// Shared types and constants of the CIA timer, time-of-day and interrupt unit.
// Used by ctu_regs and cia_timer_tod_interrupt_unit; depends on nothing.
package ctu_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } ctu_op_e;

  localparam logic [3:0] RegPra   = 4'd0;
  localparam logic [3:0] RegPrb   = 4'd1;
  localparam logic [3:0] RegDdra  = 4'd2;
  localparam logic [3:0] RegDdrb  = 4'd3;
  localparam logic [3:0] RegTaLo  = 4'd4;
  localparam logic [3:0] RegTaHi  = 4'd5;
  localparam logic [3:0] RegTbLo  = 4'd6;
  localparam logic [3:0] RegTbHi  = 4'd7;
  localparam logic [3:0] RegTodLo = 4'd8;
  localparam logic [3:0] RegTodMd = 4'd9;
  localparam logic [3:0] RegTodHi = 4'd10;
  localparam logic [3:0] RegSdr   = 4'd12;
  localparam logic [3:0] RegIcr   = 4'd13;
  localparam logic [3:0] RegCra   = 4'd14;
  localparam logic [3:0] RegCrb   = 4'd15;

  // control register bits
  localparam int unsigned CtlStart   = 0;
  localparam int unsigned CtlOneShot = 3;
  localparam int unsigned CtlLoad    = 4;
  localparam int unsigned CtlAlarm   = 7;

  localparam logic [7:0] CtlResetVal = 8'h04;
  localparam logic [7:0] RunMaskA    = 8'h21;
  localparam logic [7:0] RunMaskB    = 8'h61;
  localparam logic [7:0] RunTick     = 8'h01;
  localparam logic [7:0] RunCascade  = 8'h41;

  localparam int unsigned FlagTa    = 0;
  localparam int unsigned FlagTb    = 1;
  localparam int unsigned FlagAlarm = 2;
  localparam int unsigned FlagIrq   = 7;

  localparam int unsigned PrescW = 4;

  typedef struct packed {
    ctu_op_e    op;
    logic [3:0] address;
    logic [7:0] write_data;
    logic       tod_pulse;
  } ctu_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
  } ctu_res_t;

endpackage

[rtl/ctu_regs.sv]
// Register file and single-pass state update: timers, time of day, interrupts.
// Depends on ctu_pkg.
module ctu_regs #(
  parameter int unsigned PRESCALE = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  ctu_pkg::ctu_req_t req_i,
  output ctu_pkg::ctu_res_t res_o
);

  localparam int unsigned PrescW1 = ctu_pkg::PrescW + 1;

  logic [15:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [15:0] rld_a_q, rld_a_d, rld_b_q, rld_b_d;
  logic [7:0]  cra_q, cra_d, crb_q, crb_d;
  logic [7:0]  flags_q, flags_d;
  logic [6:0]  mask_q, mask_d;
  logic [23:0] tod_q, tod_d, alarm_q, alarm_d, snap_q, snap_d;
  logic        held_q, held_d;
  logic [7:0]  pra_q, pra_d, prb_q, prb_d, ddra_q, ddra_d, ddrb_q, ddrb_d;
  logic [7:0]  sdr_q, sdr_d;
  logic [ctu_pkg::PrescW-1:0] presc_q, presc_d;

  logic [7:0]  rdata;
  logic [PrescW1-1:0] presc_n;
  logic        step, run_a, casc, run_b, ua, ub;
  logic [23:0] tod_wr, tod_sel;

  always_comb begin
    cnt_a_d = cnt_a_q;  cnt_b_d = cnt_b_q;
    rld_a_d = rld_a_q;  rld_b_d = rld_b_q;
    cra_d   = cra_q;    crb_d   = crb_q;
    flags_d = flags_q;  mask_d  = mask_q;
    tod_d   = tod_q;    alarm_d = alarm_q;
    snap_d  = snap_q;   held_d  = held_q;
    pra_d   = pra_q;    prb_d   = prb_q;
    ddra_d  = ddra_q;   ddrb_d  = ddrb_q;
    sdr_d   = sdr_q;    presc_d = presc_q;
    rdata   = 8'h00;
    presc_n = {1'b0, presc_q} + PrescW1'(1);
    step    = 1'b0;
    run_a   = 1'b0;
    casc    = 1'b0;
    run_b   = 1'b0;
    ua      = 1'b0;
    ub      = 1'b0;
    tod_sel = crb_q[ctu_pkg::CtlAlarm] ? alarm_q : tod_q;
    tod_wr  = tod_sel;

    case (req_i.op)
      ctu_pkg::OP_READ: begin
        case (req_i.address)
          ctu_pkg::RegPra:  rdata = pra_q;
          ctu_pkg::RegPrb:  rdata = prb_q;
          ctu_pkg::RegDdra: rdata = ddra_q;
          ctu_pkg::RegDdrb: rdata = ddrb_q;
          ctu_pkg::RegTaLo: rdata = cnt_a_q[7:0];
          ctu_pkg::RegTaHi: rdata = cnt_a_q[15:8];
          ctu_pkg::RegTbLo: rdata = cnt_b_q[7:0];
          ctu_pkg::RegTbHi: rdata = cnt_b_q[15:8];
          ctu_pkg::RegTodLo: begin
            rdata  = held_q ? snap_q[7:0] : tod_q[7:0];
            held_d = 1'b0;
          end
          ctu_pkg::RegTodMd: rdata = held_q ? snap_q[15:8] : tod_q[15:8];
          ctu_pkg::RegTodHi: begin
            held_d = 1'b1;
            snap_d = tod_q;
            rdata  = tod_q[23:16];
          end
          ctu_pkg::RegSdr: rdata = sdr_q;
          ctu_pkg::RegIcr: begin
            rdata   = flags_q;
            flags_d = 8'h00;
          end
          ctu_pkg::RegCra: rdata = cra_q;
          ctu_pkg::RegCrb: rdata = crb_q;
          default: rdata = 8'h00;
        endcase
      end
      ctu_pkg::OP_WRITE: begin
        case (req_i.address)
          ctu_pkg::RegPra:  pra_d = {pra_q[7:2], req_i.write_data[1:0]};
          ctu_pkg::RegPrb:  prb_d = req_i.write_data;
          ctu_pkg::RegDdra: ddra_d = req_i.write_data;
          ctu_pkg::RegDdrb: ddrb_d = req_i.write_data;
          ctu_pkg::RegTaLo: rld_a_d = {rld_a_q[15:8], req_i.write_data};
          ctu_pkg::RegTaHi: begin
            rld_a_d = {req_i.write_data, rld_a_q[7:0]};
            if (!cra_q[ctu_pkg::CtlStart]) cnt_a_d = rld_a_d;
            if (cra_q[ctu_pkg::CtlOneShot]) begin
              cnt_a_d = rld_a_d;
              cra_d[ctu_pkg::CtlStart] = 1'b1;
            end
          end
          ctu_pkg::RegTbLo: rld_b_d = {rld_b_q[15:8], req_i.write_data};
          ctu_pkg::RegTbHi: begin
            rld_b_d = {req_i.write_data, rld_b_q[7:0]};
            if (!crb_q[ctu_pkg::CtlStart]) cnt_b_d = rld_b_d;
            if (crb_q[ctu_pkg::CtlOneShot]) begin
              cnt_b_d = rld_b_d;
              crb_d[ctu_pkg::CtlStart] = 1'b1;
            end
          end
          ctu_pkg::RegTodLo, ctu_pkg::RegTodMd, ctu_pkg::RegTodHi: begin
            if (req_i.address == ctu_pkg::RegTodLo) tod_wr[7:0] = req_i.write_data;
            else if (req_i.address == ctu_pkg::RegTodMd) tod_wr[15:8] = req_i.write_data;
            else tod_wr[23:16] = req_i.write_data;
            if (crb_q[ctu_pkg::CtlAlarm]) alarm_d = tod_wr;
            else tod_d = tod_wr;
          end
          ctu_pkg::RegSdr: sdr_d = req_i.write_data;
          ctu_pkg::RegIcr: begin
            if (req_i.write_data[7]) mask_d = mask_q | req_i.write_data[6:0];
            else mask_d = mask_q & ~req_i.write_data[6:0];
          end
          ctu_pkg::RegCra: begin
            cra_d = req_i.write_data;
            cra_d[ctu_pkg::CtlLoad] = 1'b0;
            if (req_i.write_data[ctu_pkg::CtlLoad]) cnt_a_d = rld_a_q;
          end
          ctu_pkg::RegCrb: begin
            crb_d = req_i.write_data;
            crb_d[ctu_pkg::CtlLoad] = 1'b0;
            if (req_i.write_data[ctu_pkg::CtlLoad]) cnt_b_d = rld_b_q;
          end
          default: ;
        endcase
      end
      ctu_pkg::OP_TICK: begin
        if (presc_n >= PrescW1'(PRESCALE)) begin
          presc_d = '0;
          step    = 1'b1;
        end else begin
          presc_d = presc_n[ctu_pkg::PrescW-1:0];
        end
        run_a = step && ((cra_q & ctu_pkg::RunMaskA) == ctu_pkg::RunTick);
        run_b = step && ((crb_q & ctu_pkg::RunMaskB) == ctu_pkg::RunTick);
        ua    = run_a && (cnt_a_q == 16'h0000);
        casc  = ua && ((crb_q & ctu_pkg::RunMaskB) == ctu_pkg::RunCascade);
        ub    = (casc || run_b) && (cnt_b_q == 16'h0000);
        if (run_a) cnt_a_d = cnt_a_q - 16'd1;
        if (casc || run_b) cnt_b_d = cnt_b_q - 16'd1;
        if (ua) begin
          flags_d[ctu_pkg::FlagTa] = 1'b1;
          cnt_a_d = rld_a_q;
          if (cra_q[ctu_pkg::CtlOneShot]) cra_d[ctu_pkg::CtlStart] = 1'b0;
        end
        if (ub) begin
          flags_d[ctu_pkg::FlagTb] = 1'b1;
          cnt_b_d = rld_b_q;
          if (crb_q[ctu_pkg::CtlOneShot]) crb_d[ctu_pkg::CtlStart] = 1'b0;
        end
        if (req_i.tod_pulse) begin
          tod_d = tod_q + 24'd1;
          if (tod_d == alarm_q) flags_d[ctu_pkg::FlagAlarm] = 1'b1;
        end
      end
      default: ;
    endcase

    flags_d[ctu_pkg::FlagIrq] = |(flags_d[6:0] & mask_d);
  end

  assign res_o.read_data = rdata;
  assign res_o.irq       = flags_d[ctu_pkg::FlagIrq];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q <= '0;  cnt_b_q <= '0;
      rld_a_q <= '0;  rld_b_q <= '0;
      cra_q   <= ctu_pkg::CtlResetVal;
      crb_q   <= ctu_pkg::CtlResetVal;
      flags_q <= '0;  mask_q  <= '0;
      tod_q   <= '0;  alarm_q <= '0;
      snap_q  <= '0;  held_q  <= 1'b0;
      pra_q   <= '0;  prb_q   <= '0;
      ddra_q  <= '0;  ddrb_q  <= '0;
      sdr_q   <= '0;  presc_q <= '0;
    end else if (en_i) begin
      cnt_a_q <= cnt_a_d;  cnt_b_q <= cnt_b_d;
      rld_a_q <= rld_a_d;  rld_b_q <= rld_b_d;
      cra_q   <= cra_d;    crb_q   <= crb_d;
      flags_q <= flags_d;  mask_q  <= mask_d;
      tod_q   <= tod_d;    alarm_q <= alarm_d;
      snap_q  <= snap_d;   held_q  <= held_d;
      pra_q   <= pra_d;    prb_q   <= prb_d;
      ddra_q  <= ddra_d;   ddrb_q  <= ddrb_d;
      sdr_q   <= sdr_d;    presc_q <= presc_d;
    end
  end

  a_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q[ctu_pkg::FlagIrq] == |(flags_q[6:0] & mask_q))
    else $error("interrupt summary out of step with flags and mask");

  a_presc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, presc_q} < PrescW1'(PRESCALE))
    else $error("prescaler beyond its period");

  a_no_load_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cra_q[ctu_pkg::CtlLoad] && !crb_q[ctu_pkg::CtlLoad])
    else $error("force-load bit stored in a control register");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> (cnt_a_q == $past(cnt_a_q)) && (tod_q == $past(tod_q))
              && (flags_q == $past(flags_q)))
    else $error("state changed without a request");

endmodule

[rtl/cia_timer_tod_interrupt_unit.sv]
// Top level of the CIA timer, time-of-day and interrupt unit.
// Depends on ctu_pkg and ctu_regs.
//
// Each request (register read, register write or one clock tick) is taken
// into an input register (req_q) and answered from a result register (res_q)
// holding read_data and the interrupt level. The state update is one pass of
// logic in ctu_regs, so while the result is not stalled a request is taken
// every cycle: one request per cycle sustained. A stalled result stops
// the input side only once both registers are full.
module cia_timer_tod_interrupt_unit #(
  parameter int unsigned PRESCALE = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic [3:0] address_i,
  input  logic [7:0] write_data_i,
  input  logic       tod_pulse_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic       irq_o
);

  logic              in_vld_q, in_vld_d, out_vld_q, out_vld_d;
  logic              hold, accept, adv;
  ctu_pkg::ctu_req_t req_q, req_in;
  ctu_pkg::ctu_res_t res_q, res_d;

  assign hold       = out_vld_q && out_stall_i;
  assign in_stall_o = in_vld_q && hold;
  assign accept     = in_valid_i && !in_stall_o;
  assign adv        = in_vld_q && !hold;

  assign req_in.op         = ctu_pkg::ctu_op_e'(op_i);
  assign req_in.address    = address_i;
  assign req_in.write_data = write_data_i;
  assign req_in.tod_pulse  = tod_pulse_i;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) in_vld_d = 1'b1;
    else if (adv) in_vld_d = 1'b0;
    out_vld_d = out_vld_q;
    if (adv) out_vld_d = 1'b1;
    else if (!out_stall_i) out_vld_d = 1'b0;
  end

  ctu_regs #(
    .PRESCALE(PRESCALE)
  ) u_regs (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .req_i (req_q),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_in;
    if (adv) res_q <= res_d;
  end

  assign out_valid_o = out_vld_q;
  assign read_data_o = res_q.read_data;
  assign irq_o       = res_q.irq;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_vld_q)
    else $error("input stalled with a free register");

  a_adv_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("result lost after an advance");

  a_held_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |=> in_vld_q)
    else $error("pending request dropped");

endmodule
